[hw/rtl/bric_pkg.sv]
// Shared types, constants and width helpers for the box region IoU classifier.
`timescale 1ns / 1ps

package bric_pkg;

    // Default number of coordinate bits taken from each box edge.
    localparam int DEF_COORD_BITS = 12;

    // Configuration register file.
    localparam int CFG_W       = 13;
    localparam int CFG_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Register index, taken from the word address bit of paddr.
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    // Result field widths.
    localparam int OVERLAP_W = 29;
    localparam int UNION_W   = 30;

    localparam int NUM_REGIONS = 5;

    typedef enum logic [2:0] {
        REGION_LT     = 3'd0,
        REGION_RT     = 3'd1,
        REGION_LB     = 3'd2,
        REGION_RB     = 3'd3,
        REGION_CENTER = 3'd4,
        REGION_NONE   = 3'd5
    } region_t;

    // Width of a coordinate in quarter pixels: it must hold both a box edge
    // (coord_bits + 2 bits) and four times the largest image size.
    function automatic int quarter_w(int coord_bits);
        int box_w;
        int img_w;
        box_w = coord_bits + 2;
        img_w = CFG_W + 2;
        return (box_w > img_w) ? box_w : img_w;
    endfunction

endpackage

[hw/rtl/bric_regs.sv]
// APB-style configuration registers holding the image width and height.
`timescale 1ns / 1ps

module bric_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bric_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bric_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bric_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [bric_pkg::CFG_W-1:0]         image_width,
    output logic [bric_pkg::CFG_W-1:0]         image_height
);
    import bric_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_next;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] height_next;
    logic             wr_en;
    logic             idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[2];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_en)
        begin
            case (idx)
                CFG_IDX_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                CFG_IDX_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:        width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (idx)
            CFG_IDX_WIDTH:  prdata = APB_DATA_W'(width_reg);
            CFG_IDX_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:        prdata = '0;
        endcase
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

[hw/rtl/bric_clip.sv]
// First pipeline stage: quarter-pixel bounds, clipping against the regions, extents.
`timescale 1ns / 1ps

module bric_clip
#(
    parameter int COORD_BITS = bric_pkg::DEF_COORD_BITS,
    parameter int EW         = bric_pkg::quarter_w(COORD_BITS) + 1
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COORD_BITS-1:0]                 box_left,
    input  logic [COORD_BITS-1:0]                 box_top,
    input  logic [COORD_BITS-1:0]                 box_right,
    input  logic [COORD_BITS-1:0]                 box_bottom,
    input  logic [bric_pkg::CFG_W-1:0]            image_width,
    input  logic [bric_pkg::CFG_W-1:0]            image_height,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  bad,
    output logic [EW-1:0]                         box_ext_x,
    output logic [EW-1:0]                         box_ext_y,
    output logic [EW-1:0]                         reg_ext_x,
    output logic [EW-1:0]                         reg_ext_y,
    output logic [bric_pkg::NUM_REGIONS-1:0][EW-1:0] ovl_ext_x,
    output logic [bric_pkg::NUM_REGIONS-1:0][EW-1:0] ovl_ext_y
);
    import bric_pkg::*;

    localparam int CW = EW - 1;

    logic [CW-1:0] bx0, by0, bx1, by1;
    logic [CW-1:0] w1, w2, w3, w4;
    logic [CW-1:0] h1, h2, h3, h4;
    logic [NUM_REGIONS-1:0][CW-1:0] rx_lo, rx_hi, ry_lo, ry_hi;
    logic [NUM_REGIONS-1:0][CW-1:0] cx0, cx1, cy0, cy1;

    logic                            valid_reg;
    logic                            bad_next, bad_reg;
    logic [EW-1:0]                   bx_next, by_next, rx_next, ry_next;
    logic [EW-1:0]                   bx_reg, by_reg, rx_reg, ry_reg;
    logic [NUM_REGIONS-1:0][EW-1:0]  ox_next, oy_next, ox_reg, oy_reg;

    assign bx0 = CW'({box_left,   2'b00});
    assign by0 = CW'({box_top,    2'b00});
    assign bx1 = CW'({box_right,  2'b00});
    assign by1 = CW'({box_bottom, 2'b00});

    assign w1 = CW'(image_width);
    assign w2 = CW'({image_width, 1'b0});
    assign w4 = CW'({image_width, 2'b00});
    assign w3 = w2 + w1;
    assign h1 = CW'(image_height);
    assign h2 = CW'({image_height, 1'b0});
    assign h4 = CW'({image_height, 2'b00});
    assign h3 = h2 + h1;

    // Region bounds in quarter pixels: four quadrants, then the center box.
    always_comb
    begin
        rx_lo[REGION_LT] = '0; rx_hi[REGION_LT] = w2;
        ry_lo[REGION_LT] = '0; ry_hi[REGION_LT] = h2;
        rx_lo[REGION_RT] = w2; rx_hi[REGION_RT] = w4;
        ry_lo[REGION_RT] = '0; ry_hi[REGION_RT] = h2;
        rx_lo[REGION_LB] = '0; rx_hi[REGION_LB] = w2;
        ry_lo[REGION_LB] = h2; ry_hi[REGION_LB] = h4;
        rx_lo[REGION_RB] = w2; rx_hi[REGION_RB] = w4;
        ry_lo[REGION_RB] = h2; ry_hi[REGION_RB] = h4;
        rx_lo[REGION_CENTER] = w1; rx_hi[REGION_CENTER] = w3;
        ry_lo[REGION_CENTER] = h1; ry_hi[REGION_CENTER] = h3;
    end

    // Clip the box to each region; a region without overlap gets zero extents,
    // so its intersection area comes out as zero further down.
    always_comb
    begin
        for (int k = 0; k < NUM_REGIONS; k++)
        begin
            cx0[k] = (bx0 > rx_lo[k]) ? bx0 : rx_lo[k];
            cy0[k] = (by0 > ry_lo[k]) ? by0 : ry_lo[k];
            cx1[k] = (bx1 < rx_hi[k]) ? bx1 : rx_hi[k];
            cy1[k] = (by1 < ry_hi[k]) ? by1 : ry_hi[k];
            if ((cx1[k] >= cx0[k]) && (cy1[k] >= cy0[k]))
            begin
                ox_next[k] = {1'b0, cx1[k] - cx0[k]} + EW'(4);
                oy_next[k] = {1'b0, cy1[k] - cy0[k]} + EW'(4);
            end
            else
            begin
                ox_next[k] = '0;
                oy_next[k] = '0;
            end
        end
    end

    assign bad_next = (box_right < box_left) || (box_bottom < box_top);
    assign bx_next  = {1'b0, bx1 - bx0} + EW'(4);
    assign by_next  = {1'b0, by1 - by0} + EW'(4);
    assign rx_next  = {1'b0, w2} + EW'(4);
    assign ry_next  = {1'b0, h2} + EW'(4);

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bad_reg <= bad_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
        end
    end

    assign out_valid = valid_reg;
    assign bad       = bad_reg;
    assign box_ext_x = bx_reg;
    assign box_ext_y = by_reg;
    assign reg_ext_x = rx_reg;
    assign reg_ext_y = ry_reg;
    assign ovl_ext_x = ox_reg;
    assign ovl_ext_y = oy_reg;

endmodule

[hw/rtl/bric_mul.sv]
// Second pipeline stage: area multipliers, one lane per region plus box and region areas.
`timescale 1ns / 1ps

module bric_mul
#(
    parameter int EW = bric_pkg::quarter_w(bric_pkg::DEF_COORD_BITS) + 1,
    parameter int AW = 2 * EW
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   bad_in,
    input  logic [EW-1:0]                          box_ext_x,
    input  logic [EW-1:0]                          box_ext_y,
    input  logic [EW-1:0]                          reg_ext_x,
    input  logic [EW-1:0]                          reg_ext_y,
    input  logic [bric_pkg::NUM_REGIONS-1:0][EW-1:0] ovl_ext_x,
    input  logic [bric_pkg::NUM_REGIONS-1:0][EW-1:0] ovl_ext_y,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   bad,
    output logic [AW-1:0]                          box_area,
    output logic [AW-1:0]                          reg_area,
    output logic [bric_pkg::NUM_REGIONS-1:0][AW-1:0] inter
);
    import bric_pkg::*;

    logic                            valid_reg;
    logic                            bad_reg;
    logic [AW-1:0]                   box_area_next, box_area_reg;
    logic [AW-1:0]                   reg_area_next, reg_area_reg;
    logic [NUM_REGIONS-1:0][AW-1:0]  inter_next, inter_reg;

    assign box_area_next = AW'(box_ext_x) * AW'(box_ext_y);
    assign reg_area_next = AW'(reg_ext_x) * AW'(reg_ext_y);

    always_comb
    begin
        for (int k = 0; k < NUM_REGIONS; k++)
        begin
            inter_next[k] = AW'(ovl_ext_x[k]) * AW'(ovl_ext_y[k]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bad_reg      <= bad_in;
            box_area_reg <= box_area_next;
            reg_area_reg <= reg_area_next;
            inter_reg    <= inter_next;
        end
    end

    assign out_valid = valid_reg;
    assign bad       = bad_reg;
    assign box_area  = box_area_reg;
    assign reg_area  = reg_area_reg;
    assign inter     = inter_reg;

endmodule

[hw/rtl/bric_select.sv]
// Third and fourth pipeline stages: two-level selection of the largest intersection.
`timescale 1ns / 1ps

module bric_select
#(
    parameter int AW = 2 * (bric_pkg::quarter_w(bric_pkg::DEF_COORD_BITS) + 1)
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   bad_in,
    input  logic [AW-1:0]                          box_area_in,
    input  logic [AW-1:0]                          reg_area_in,
    input  logic [bric_pkg::NUM_REGIONS-1:0][AW-1:0] inter,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   bad,
    output logic [AW-1:0]                          box_area,
    output logic [AW-1:0]                          reg_area,
    output bric_pkg::region_t                      best_region,
    output logic [AW-1:0]                          best_inter
);
    import bric_pkg::*;

    // Every region has the same area and the box area is common to all of
    // them, so the union falls as the intersection grows: the highest IoU
    // belongs to the largest intersection. Ties keep the earlier region.

    logic        ready_a, ready_b;
    logic        valid_a_reg, valid_b_reg;

    // Stage A: winners of the top pair and of the bottom pair.
    logic        bad_a_reg;
    logic [AW-1:0] box_a_reg, reg_a_reg;
    region_t     top_idx_next, bot_idx_next, top_idx_reg, bot_idx_reg;
    logic [AW-1:0] top_val_next, bot_val_next, top_val_reg, bot_val_reg;
    logic [AW-1:0] ctr_val_reg;

    // Stage B: overall winner.
    logic        bad_b_reg;
    logic [AW-1:0] box_b_reg, reg_b_reg;
    region_t     quad_idx, best_idx_next, best_idx_reg;
    logic [AW-1:0] quad_val, best_val_next, best_val_reg;

    always_comb
    begin
        if (inter[REGION_RT] > inter[REGION_LT])
        begin
            top_idx_next = REGION_RT;
            top_val_next = inter[REGION_RT];
        end
        else
        begin
            top_idx_next = REGION_LT;
            top_val_next = inter[REGION_LT];
        end
        if (inter[REGION_RB] > inter[REGION_LB])
        begin
            bot_idx_next = REGION_RB;
            bot_val_next = inter[REGION_RB];
        end
        else
        begin
            bot_idx_next = REGION_LB;
            bot_val_next = inter[REGION_LB];
        end
    end

    always_comb
    begin
        if (bot_val_reg > top_val_reg)
        begin
            quad_idx = bot_idx_reg;
            quad_val = bot_val_reg;
        end
        else
        begin
            quad_idx = top_idx_reg;
            quad_val = top_val_reg;
        end
        if (ctr_val_reg > quad_val)
        begin
            best_idx_next = REGION_CENTER;
            best_val_next = ctr_val_reg;
        end
        else
        begin
            best_idx_next = quad_idx;
            best_val_next = quad_val;
        end
    end

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            bad_a_reg   <= bad_in;
            box_a_reg   <= box_area_in;
            reg_a_reg   <= reg_area_in;
            top_idx_reg <= top_idx_next;
            top_val_reg <= top_val_next;
            bot_idx_reg <= bot_idx_next;
            bot_val_reg <= bot_val_next;
            ctr_val_reg <= inter[REGION_CENTER];
        end
        if (ready_b && valid_a_reg)
        begin
            bad_b_reg    <= bad_a_reg;
            box_b_reg    <= box_a_reg;
            reg_b_reg    <= reg_a_reg;
            best_idx_reg <= best_idx_next;
            best_val_reg <= best_val_next;
        end
    end

    assign out_valid   = valid_b_reg;
    assign bad         = bad_b_reg;
    assign box_area    = box_b_reg;
    assign reg_area    = reg_b_reg;
    assign best_region = best_idx_reg;
    assign best_inter  = best_val_reg;

endmodule

[hw/rtl/box_region_iou_classifier.sv]
// Top level of the box region IoU classifier: config port, pipeline and result register.
`timescale 1ns / 1ps

// Classifies one detected box, given by inclusive pixel edges, against five
// regions of the configured image: the four quadrants and a central box of
// half the image size. The block reports the region with the highest
// intersection-over-union (earlier region on a tie), together with the
// winning intersection and union areas in sixteenths of a square pixel. All
// arithmetic is exact in quarter pixels; no division takes place. A box with
// right < left or bottom < top sets bad_box and reports region "none" with
// zero areas, and a box that overlaps no region also reports "none".
// One box transfer is accepted in every cycle unless backpressure holds the
// pipeline, and each result passes through five register stages: the
// clipping stage, the area multipliers, two selection stages and the result
// register that also forms the union. Backpressure on the result channel
// holds a stage only while the stage after it is full, so empty slots close
// up, and no transfer is lost or repeated.
// The user must write image_width and image_height through the APB-style
// port (byte addresses 0 and 4, 13 bits each, reset 640 and 480) only while
// no box is in flight, unchecked by the block; reads return stored values.

module box_region_iou_classifier
#(
    parameter int COORD_BITS = bric_pkg::DEF_COORD_BITS
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bric_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bric_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bric_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [COORD_BITS-1:0]              box_left,
    input  logic [COORD_BITS-1:0]              box_top,
    input  logic [COORD_BITS-1:0]              box_right,
    input  logic [COORD_BITS-1:0]              box_bottom,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bric_pkg::region_t                  region,
    output logic [bric_pkg::OVERLAP_W-1:0]     best_overlap,
    output logic [bric_pkg::UNION_W-1:0]       best_union,
    output logic                               bad_box
);
    import bric_pkg::*;

    // Extents carry one bit more than a quarter-pixel coordinate, areas twice that.
    localparam int EW = quarter_w(COORD_BITS) + 1;
    localparam int AW = 2 * EW;

    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] image_height;

    // Clip stage outputs.
    logic                            c_valid, c_ready, c_bad;
    logic [EW-1:0]                   c_box_x, c_box_y, c_reg_x, c_reg_y;
    logic [NUM_REGIONS-1:0][EW-1:0]  c_ovl_x, c_ovl_y;

    // Multiply stage outputs.
    logic                            m_valid, m_ready, m_bad;
    logic [AW-1:0]                   m_box_area, m_reg_area;
    logic [NUM_REGIONS-1:0][AW-1:0]  m_inter;

    // Selection stage outputs.
    logic                            s_valid, s_ready, s_bad;
    logic [AW-1:0]                   s_box_area, s_reg_area, s_inter;
    region_t                         s_region;

    // Result register.
    logic                            res_valid_reg;
    region_t                         region_next, region_reg;
    logic [OVERLAP_W-1:0]            overlap_next, overlap_reg;
    logic [UNION_W-1:0]              union_next, union_reg;
    logic                            bad_next, bad_reg;
    logic [AW:0]                     union_full;
    logic                            no_hit;

    bric_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .image_width  (image_width),
        .image_height (image_height)
    );

    bric_clip #(.COORD_BITS(COORD_BITS), .EW(EW)) u_clip
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .image_width  (image_width),
        .image_height (image_height),
        .out_valid    (c_valid),
        .out_ready    (c_ready),
        .bad          (c_bad),
        .box_ext_x    (c_box_x),
        .box_ext_y    (c_box_y),
        .reg_ext_x    (c_reg_x),
        .reg_ext_y    (c_reg_y),
        .ovl_ext_x    (c_ovl_x),
        .ovl_ext_y    (c_ovl_y)
    );

    bric_mul #(.EW(EW), .AW(AW)) u_mul
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (c_valid),
        .in_ready     (c_ready),
        .bad_in       (c_bad),
        .box_ext_x    (c_box_x),
        .box_ext_y    (c_box_y),
        .reg_ext_x    (c_reg_x),
        .reg_ext_y    (c_reg_y),
        .ovl_ext_x    (c_ovl_x),
        .ovl_ext_y    (c_ovl_y),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .bad          (m_bad),
        .box_area     (m_box_area),
        .reg_area     (m_reg_area),
        .inter        (m_inter)
    );

    bric_select #(.AW(AW)) u_select
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (m_valid),
        .in_ready     (m_ready),
        .bad_in       (m_bad),
        .box_area_in  (m_box_area),
        .reg_area_in  (m_reg_area),
        .inter        (m_inter),
        .out_valid    (s_valid),
        .out_ready    (s_ready),
        .bad          (s_bad),
        .box_area     (s_box_area),
        .reg_area     (s_reg_area),
        .best_region  (s_region),
        .best_inter   (s_inter)
    );

    // The union is the box area plus the region area minus the overlap. An
    // inverted box or a box that meets no region reports "none" with zeros.
    assign union_full = (AW+1)'(s_box_area) + (AW+1)'(s_reg_area) - (AW+1)'(s_inter);
    assign no_hit     = s_bad || (s_inter == '0);

    always_comb
    begin
        bad_next = s_bad;
        if (no_hit)
        begin
            region_next  = REGION_NONE;
            overlap_next = '0;
            union_next   = '0;
        end
        else
        begin
            region_next  = s_region;
            overlap_next = s_inter[OVERLAP_W-1:0];
            union_next   = union_full[UNION_W-1:0];
        end
    end

    // The result register takes a new transfer whenever it is empty or its
    // current result is being taken in the same cycle.
    assign s_ready = !res_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            res_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            region_reg  <= region_next;
            overlap_reg <= overlap_next;
            union_reg   <= union_next;
            bad_reg     <= bad_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign region       = region_reg;
    assign best_overlap = overlap_reg;
    assign best_union   = union_reg;
    assign bad_box      = bad_reg;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the box region IoU classifier.
`timescale 1ns / 1ps

// The testbench sends detected boxes through the input channel, and a
// predictor of its own works out the region, the winning intersection and
// union areas and the bad-box flag for every box at the moment the box is
// accepted. The monitor compares each result transfer, field by field, with
// the oldest expected result.
// The run goes through several image sizes: the reset size, the smallest and
// largest legal sizes, a common video size, random sizes, and sizes outside
// the legal range, zero and 8191 among them. Each size is written through the
// APB-style port and read back while no box is in flight. Both channels idle
// at random in several mixes. One phase holds the receiver off for a long
// stretch so that the pipeline fills and stalls its input, and then stops the
// sender until every expected result has come back.
module tb_top;

    import bric_pkg::*;

    // One box transfer: inclusive pixel edges.
    typedef struct packed {
        logic [DEF_COORD_BITS-1:0] left;
        logic [DEF_COORD_BITS-1:0] top;
        logic [DEF_COORD_BITS-1:0] right;
        logic [DEF_COORD_BITS-1:0] bottom;
    } box_t;

    // One result transfer.
    typedef struct packed {
        region_t                region;
        logic [OVERLAP_W-1:0]   overlap;
        logic [UNION_W-1:0]     union_area;
        logic                   bad;
    } region_pick_t;

    // Settling time that drain() waits after the last result, before the
    // registers are touched or the run ends.
    localparam int PIPE_SETTLE = 10;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Length of the long receiver hold-off.
    localparam int LONG_HOLD = 300;
    localparam int MAX_COORD = (1 << DEF_COORD_BITS) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [DEF_COORD_BITS-1:0] box_left = '0;
    logic [DEF_COORD_BITS-1:0] box_top = '0;
    logic [DEF_COORD_BITS-1:0] box_right = '0;
    logic [DEF_COORD_BITS-1:0] box_bottom = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    region_t                   region;
    logic [OVERLAP_W-1:0]      best_overlap;
    logic [UNION_W-1:0]        best_union;
    logic                      bad_box;

    // Testbench copy of the configuration registers.
    logic [CFG_W-1:0] cfg_width = WIDTH_RESET;
    logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;

    box_t         boxes_to_send[$];
    region_pick_t expected_picks[$];

    // Idling mix, in percent of cycles.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Pressure controls: the sender hold is set by the stimulus process, the
    // long hold-off is requested there but counted in the receiver process.
    logic send_hold = 1'b0;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;
    int   long_hold_cnt = 0;

    int boxes_accepted = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    box_region_iou_classifier i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .region       (region),
        .best_overlap (best_overlap),
        .best_union   (best_union),
        .bad_box      (bad_box)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Predictor. Everything is kept in quarter pixels so that the region
    // bounds W/4, W/2 and 3W/4 are exact. IoUs are compared by
    // cross-multiplying intersection and union, so no division is needed, and
    // only a strictly larger IoU replaces the current winner: on a tie the
    // earlier region keeps it, and a region with zero overlap never wins.
    function automatic region_pick_t classify_box(box_t b, logic [CFG_W-1:0] w_px,
                                                  logic [CFG_W-1:0] h_px);
        region_pick_t       pick;
        longint             bx0, by0, bx1, by1, w, h;
        longint             rx0[NUM_REGIONS], ry0[NUM_REGIONS];
        longint             rx1[NUM_REGIONS], ry1[NUM_REGIONS];
        longint             x0, y0, x1, y1;
        longint unsigned    box_area, inter, reg_area, uni, win_inter, win_union;
        logic [127:0]       lhs, rhs;
        region_t            winner;
        int                 k;

        pick.region = REGION_NONE;
        pick.overlap = '0;
        pick.union_area = '0;
        pick.bad = 1'b0;
        bx0 = longint'(b.left) * 4;
        by0 = longint'(b.top) * 4;
        bx1 = longint'(b.right) * 4;
        by1 = longint'(b.bottom) * 4;
        w = longint'(w_px);
        h = longint'(h_px);

        // An inverted box is flagged and never classified.
        if (bx1 < bx0 || by1 < by0)
        begin
            pick.bad = 1'b1;
            return pick;
        end

        // Quadrants in reading order, then the central half-size box.
        rx0[0] = 0;     ry0[0] = 0;     rx1[0] = 2 * w; ry1[0] = 2 * h;
        rx0[1] = 2 * w; ry0[1] = 0;     rx1[1] = 4 * w; ry1[1] = 2 * h;
        rx0[2] = 0;     ry0[2] = 2 * h; rx1[2] = 2 * w; ry1[2] = 4 * h;
        rx0[3] = 2 * w; ry0[3] = 2 * h; rx1[3] = 4 * w; ry1[3] = 4 * h;
        rx0[4] = w;     ry0[4] = h;     rx1[4] = 3 * w; ry1[4] = 3 * h;

        // Inclusive bounds: an extent is hi - lo plus one pixel.
        box_area = longint'(bx1 - bx0 + 4) * longint'(by1 - by0 + 4);
        win_inter = 0;
        win_union = 1;
        winner = REGION_NONE;

        for (k = 0; k < NUM_REGIONS; k++)
        begin
            x0 = (bx0 > rx0[k]) ? bx0 : rx0[k];
            y0 = (by0 > ry0[k]) ? by0 : ry0[k];
            x1 = (bx1 < rx1[k]) ? bx1 : rx1[k];
            y1 = (by1 < ry1[k]) ? by1 : ry1[k];
            // Touching edges still overlap by one pixel; disjoint spans do not.
            if (x1 >= x0 && y1 >= y0)
            begin
                inter = longint'(x1 - x0 + 4) * longint'(y1 - y0 + 4);
                reg_area = longint'(rx1[k] - rx0[k] + 4) * longint'(ry1[k] - ry0[k] + 4);
                uni = box_area + reg_area - inter;
                lhs = 128'(inter) * 128'(win_union);
                rhs = 128'(win_inter) * 128'(uni);
                if (lhs > rhs)
                begin
                    win_inter = inter;
                    win_union = uni;
                    winner = region_t'(k);
                end
            end
        end

        if (winner != REGION_NONE)
        begin
            pick.region = winner;
            pick.overlap = win_inter[OVERLAP_W-1:0];
            pick.union_area = win_union[UNION_W-1:0];
        end
        return pick;
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > MAX_COORD)
            return MAX_COORD;
        return v;
    endfunction

    // Random box generator. Most boxes are well formed and lie inside the
    // image or straddle a region boundary, since those decide the ranking;
    // the rest are inverted boxes and boxes anywhere in the coordinate range.
    function automatic box_t make_box();
        box_t b;
        int   kind;
        int   xlim, ylim;
        int   cx, cy, a, c;

        kind = $urandom_range(99);
        xlim = (cfg_width == 0) ? 0 : clamp_coord(int'(cfg_width) - 1);
        ylim = (cfg_height == 0) ? 0 : clamp_coord(int'(cfg_height) - 1);
        if (kind < 6)
        begin
            b = box_t'($urandom);
            b.bottom = DEF_COORD_BITS'($urandom);
        end
        else if (kind < 14)
        begin
            b = box_t'($urandom);
            b.bottom = DEF_COORD_BITS'($urandom);
            if ($urandom_range(1) == 0)
            begin
                b.left = DEF_COORD_BITS'($urandom_range(1, MAX_COORD));
                b.right = DEF_COORD_BITS'($urandom_range(0, int'(b.left) - 1));
            end
            else
            begin
                b.top = DEF_COORD_BITS'($urandom_range(1, MAX_COORD));
                b.bottom = DEF_COORD_BITS'($urandom_range(0, int'(b.top) - 1));
            end
        end
        else if (kind < 60)
        begin
            b.left = DEF_COORD_BITS'($urandom_range(0, xlim));
            b.right = DEF_COORD_BITS'($urandom_range(int'(b.left), xlim));
            b.top = DEF_COORD_BITS'($urandom_range(0, ylim));
            b.bottom = DEF_COORD_BITS'($urandom_range(int'(b.top), ylim));
        end
        else if (kind < 80)
        begin
            // Straddle one of the region boundaries at a quarter, a half or
            // three quarters of the image.
            cx = (int'(cfg_width) * $urandom_range(1, 3)) / 4;
            cy = (int'(cfg_height) * $urandom_range(1, 3)) / 4;
            b.left = DEF_COORD_BITS'(clamp_coord(cx - $urandom_range(0, 40)));
            b.right = DEF_COORD_BITS'(clamp_coord(cx + $urandom_range(0, 40)));
            b.top = DEF_COORD_BITS'(clamp_coord(cy - $urandom_range(0, 40)));
            b.bottom = DEF_COORD_BITS'(clamp_coord(cy + $urandom_range(0, 40)));
        end
        else
        begin
            a = $urandom_range(0, MAX_COORD);
            c = $urandom_range(0, MAX_COORD);
            b.left = DEF_COORD_BITS'((a < c) ? a : c);
            b.right = DEF_COORD_BITS'((a < c) ? c : a);
            a = $urandom_range(0, MAX_COORD);
            c = $urandom_range(0, MAX_COORD);
            b.top = DEF_COORD_BITS'((a < c) ? a : c);
            b.bottom = DEF_COORD_BITS'((a < c) ? c : a);
        end
        return b;
    endfunction

    // Driver. A box is offered only when the channel is free; once offered,
    // valid and the edges stay put until the transfer happens. The expected
    // result is computed at the transfer edge with the configuration in force.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_picks.push_back(classify_box(boxes_to_send[0], cfg_width,
                                                      cfg_height));
                void'(boxes_to_send.pop_front());
                boxes_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (boxes_to_send.size() != 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    box_left <= boxes_to_send[0].left;
                    box_top <= boxes_to_send[0].top;
                    box_right <= boxes_to_send[0].right;
                    box_bottom <= boxes_to_send[0].bottom;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Monitor. Each result transfer is checked against the oldest expected
    // result. The receiver stalls at random, and on request it holds ready
    // low for a long stretch that it counts itself.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    $display("%0t: result transfer with no box outstanding", $time);
                    error_count++;
                end
                else
                begin
                    check_field("region", 64'(expected_picks[0].region), 64'(region));
                    check_field("best_overlap", 64'(expected_picks[0].overlap),
                                64'(best_overlap));
                    check_field("best_union", 64'(expected_picks[0].union_area),
                                64'(best_union));
                    check_field("bad_box", 64'(expected_picks[0].bad), 64'(bad_box));
                    void'(expected_picks.pop_front());
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                if (long_hold_cnt == LONG_HOLD)
                begin
                    long_hold_done <= 1'b1;
                    out_ready <= 1'b1;
                end
                else
                begin
                    long_hold_cnt++;
                    out_ready <= 1'b0;
                end
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: a run that makes no transfer for too long has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // One APB-style access: setup cycle, then access cycle. For a read the
    // data is taken at the edge that completes the access.
    task automatic apb_access(logic wr, logic idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Reads a register back and compares it with the testbench copy.
    task automatic check_register(logic idx, logic [CFG_W-1:0] want);
        logic [APB_DATA_W-1:0] rdata;

        apb_access(1'b0, idx, '0, rdata);
        if (rdata != APB_DATA_W'(want))
        begin
            $display("%0t: register %0d readback, expected %0d, got %0d",
                     $time, idx, want, rdata);
            error_count++;
        end
    endtask

    // Writes both image size registers, with junk in the unused upper bits,
    // and reads them back. The block must be idle when this is called.
    task automatic set_image_size(int w, int h);
        logic [APB_DATA_W-1:0] junk;
        logic [APB_DATA_W-1:0] unused;

        junk = $urandom & ~APB_DATA_W'((1 << CFG_W) - 1);
        apb_access(1'b1, CFG_IDX_WIDTH, junk | APB_DATA_W'(w), unused);
        cfg_width = CFG_W'(w);
        junk = $urandom & ~APB_DATA_W'((1 << CFG_W) - 1);
        apb_access(1'b1, CFG_IDX_HEIGHT, junk | APB_DATA_W'(h), unused);
        cfg_height = CFG_W'(h);
        check_register(CFG_IDX_WIDTH, cfg_width);
        check_register(CFG_IDX_HEIGHT, cfg_height);
    endtask

    task automatic queue_box(int l, int t, int r, int b);
        box_t bx;

        bx.left = DEF_COORD_BITS'(l);
        bx.top = DEF_COORD_BITS'(t);
        bx.right = DEF_COORD_BITS'(r);
        bx.bottom = DEF_COORD_BITS'(b);
        boxes_to_send.push_back(bx);
    endtask

    // Waits until every box has been sent and every result has come back,
    // then lets the pipeline settle.
    task automatic drain();
        while (boxes_to_send.size() != 0 || expected_picks.size() != 0 || in_valid)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic run_random(int count, int idle_pct, int stall_pct);
        int n;

        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < count; n++)
            boxes_to_send.push_back(make_box());
        drain();
    endtask

    // Stimulus sequence.
    initial
    begin
        int start_count;
        int n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset image size is 640 by 480.
        check_register(CFG_IDX_WIDTH, WIDTH_RESET);
        check_register(CFG_IDX_HEIGHT, HEIGHT_RESET);

        // Directed boxes at the reset size, no idling.
        queue_box(0, 0, 0, 0);                  // single pixel at the origin
        queue_box(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD); // far outside
        queue_box(0, 0, MAX_COORD, MAX_COORD);  // whole coordinate range
        queue_box(0, 0, 639, 479);              // whole image: left top ties center, first wins
        queue_box(0, 0, 319, 239);              // left top quadrant less its last row and column
        queue_box(320, 0, 639, 239);            // right top quadrant less its last row and column
        queue_box(0, 240, 319, 479);            // left bottom quadrant less its last row and column
        queue_box(320, 240, 639, 479);          // right bottom quadrant less its last row and column
        queue_box(160, 120, 479, 359);          // center box less its last row and column
        queue_box(320, 100, 320, 100);          // on the shared vertical edge
        queue_box(640, 480, 700, 500);          // touching the outer corner
        queue_box(641, 481, 700, 500);          // just past the image
        queue_box(10, 0, 9, 5);                 // right left of left
        queue_box(0, 10, 5, 9);                 // bottom above top
        queue_box(MAX_COORD, MAX_COORD, 0, 0);  // inverted on both axes
        queue_box(MAX_COORD, 0, MAX_COORD, 0);  // extremes, still well formed
        queue_box(0, MAX_COORD, MAX_COORD, MAX_COORD);
        queue_box(300, 200, 340, 260);          // straddles all four quadrants
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        // Smallest legal image, no idling.
        set_image_size(1, 1);
        run_random(60, 0, 0);

        // Largest legal image, sender idling.
        set_image_size(4096, 4096);
        run_random(80, 49, 0);

        // Receiver stalling. The long hold-off fills the pipeline while the
        // sender keeps offering boxes; later the sender stops until every
        // result is back.
        set_image_size(1920, 1080);
        send_idle_pct = 0;
        recv_stall_pct = 49;
        long_hold_req = 1'b1;
        start_count = boxes_accepted;
        for (n = 0; n < 80; n++)
            boxes_to_send.push_back(make_box());
        while (boxes_accepted < start_count + 40)
            @(posedge clk);
        send_hold = 1'b1;
        while (expected_picks.size() != 0 || in_valid)
            @(posedge clk);
        send_hold = 1'b0;
        drain();

        // Random legal size, both sides idling.
        set_image_size($urandom_range(1, 4096), $urandom_range(1, 4096));
        run_random(80, 22, 22);

        // Sizes outside the legal range are used as written.
        set_image_size(0, (1 << CFG_W) - 1);
        run_random(60, 22, 22);
        set_image_size((1 << CFG_W) - 1, 0);
        run_random(40, 49, 0);

        // Another random size, receiver stalling, then no idling at all.
        set_image_size($urandom_range(1, 4096), $urandom_range(1, 4096));
        run_random(40, 0, 49);
        run_random(40, 0, 0);

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
